### rtl/lcg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lcg_pkg
// Constants, request codes and sequencer states of the 48-bit LCG source.
// ----------------------------------------------------------------------------
package lcg_pkg;

	localparam int unsigned STATE_W = 48;
	localparam int unsigned MULT_W  = 35;
	localparam int unsigned CHUNK_W = 16;
	localparam int unsigned VALUE_W = 54;
	localparam int unsigned BOUND_W = 31;

	localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5_DEEC_E66D;
	localparam logic [STATE_W-1:0] LCG_ADD  = 48'hB;

	localparam logic [2:0] KIND_RAW  = 3'd0;
	localparam logic [2:0] KIND_INT  = 3'd1;
	localparam logic [2:0] KIND_BOOL = 3'd2;
	localparam logic [2:0] KIND_F24  = 3'd3;
	localparam logic [2:0] KIND_D53  = 3'd4;

	localparam logic [1:0] LAST_CHUNK = 2'd2;
	localparam logic [4:0] LAST_DIV   = 5'd30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_EVAL,
		ST_DIV,
		ST_CHECK,
		ST_DONE
	} seq_state_t;

	typedef struct packed {
		logic start_mul;
		logic mul_last;
		logic eval_done;
		logic reject;
	} seq_ctl_t;

endpackage
`default_nettype wire

### rtl/lcg48_random_source.sv
`timescale 1ns / 1ps
`default_nettype none
// Raw, boolean and float24 requests take one draw from accept to result beat; double53
// takes two draws. A bounded int with a power-of-two bound takes one draw scaled by the
// bound, otherwise one draw through a bit-serial restoring divider, each rejected draw
// bringing a redraw. Throughput: one request at a time, the next one accepted once the
// result register is free and the sequencer is idle again. Unused kinds and a zero bound
// take no draw. Reset: asynchronous, active low; state = 0x5DEECE66D, seed register = 0.
// ----------------------------------------------------------------------------
// lcg48_random_source
// 48-bit linear congruential random source with a shared 16x35 multiplier
// and a bit-serial divider for bounded requests.
// ----------------------------------------------------------------------------
module lcg48_random_source (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [3:0]          paddr,
	input  wire logic [63:0]         pwdata,
	output logic      [63:0]         prdata,
	output logic                     pready,
	// request channel
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire logic [2:0]          kind,
	input  wire logic [5:0]          bit_count,
	input  wire logic [30:0]         bound,
	// result channel
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output logic signed [53:0]       value
);

	localparam int unsigned SW = lcg_pkg::STATE_W;
	localparam int unsigned BW = lcg_pkg::BOUND_W;
	localparam int unsigned VW = lcg_pkg::VALUE_W;
	localparam int unsigned CHUNK_W_L = lcg_pkg::CHUNK_W;

	lcg_pkg::seq_state_t st_q, st_nx;
	lcg_pkg::seq_ctl_t   ctl;

	logic [SW-1:0]      seed_q;
	logic [SW-1:0]      state_q;
	logic [SW-1:0]      acc_q;
	logic [1:0]         chunk_q;
	logic [2:0]         kind_q;
	logic [5:0]         nbits_q;
	logic [BW-1:0]      bound_q;
	logic               second_q;
	logic [25:0]        hi_q;
	logic [BW-1:0]      r_q;
	logic [BW-1:0]      dvd_q;
	logic [BW:0]        rem_q;
	logic [4:0]         div_cnt_q;
	logic [VW-1:0]      res_q;
	logic               rsp_valid_q;
	logic [VW-1:0]      value_q;

	logic               cfg_wr;
	logic               req_acc;
	logic               rsp_acc;
	logic               kind_ok;
	logic [CHUNK_W_L-1:0] chunk;
	logic [CHUNK_W_L+lcg_pkg::MULT_W-1:0] prod;
	logic [SW-1:0]      part;
	logic [SW-1:0]      acc_sum;
	logic [31:0]        top32;
	logic [31:0]        raw_sh;
	logic [VW-1:0]      raw_val;
	logic [BW-1:0]      draw31;
	logic               pow2;
	logic [2*BW-1:0]    pow_prod;
	logic [BW:0]        rem_sh;
	logic [BW:0]        rem_nx;
	logic [BW+1:0]      chk;
	logic [5:0]         nbits_in;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & ~paddr[3];
	assign prdata  = paddr[3] ? 64'd0 : {{(64-SW){1'b0}}, seed_q};

	assign req_acc   = req_valid & ~req_stall;
	assign rsp_acc   = rsp_valid_q & ~rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign value     = signed'(value_q);

	assign kind_ok = (kind == lcg_pkg::KIND_RAW) || (kind == lcg_pkg::KIND_BOOL) ||
			(kind == lcg_pkg::KIND_F24) || (kind == lcg_pkg::KIND_D53) ||
			((kind == lcg_pkg::KIND_INT) && (bound != '0));
	assign nbits_in = (bit_count > 6'd32) ? 6'd32 : bit_count;

	// shared multiplier: one 16-bit slice of the state per cycle
	always_comb begin
		case (chunk_q)
			2'd0:    chunk = state_q[15:0];
			2'd1:    chunk = state_q[31:16];
			default: chunk = state_q[47:32];
		endcase
		prod = chunk * lcg_pkg::LCG_MULT;
		case (chunk_q)
			2'd0:    part = prod[47:0];
			2'd1:    part = {prod[31:0], 16'd0};
			default: part = {prod[15:0], 32'd0};
		endcase
		acc_sum = acc_q + part;
	end

	// result forms from the fresh state
	always_comb begin
		top32   = state_q[47:16];
		raw_sh  = top32 >> (6'd32 - nbits_q);
		if (nbits_q == 6'd0) begin
			raw_val = '0;
		end else if (nbits_q == 6'd32) begin
			raw_val = {{(VW-32){top32[31]}}, top32};
		end else begin
			raw_val = {{(VW-32){1'b0}}, raw_sh};
		end
		draw31   = state_q[47:17];
		pow2     = (bound_q & (~bound_q + BW'(1))) == bound_q;
		pow_prod = bound_q * draw31;
		rem_sh   = {rem_q[BW-1:0], dvd_q[BW-1]};
		rem_nx   = (rem_sh >= {1'b0, bound_q}) ? rem_sh - {1'b0, bound_q} : rem_sh;
		chk      = {2'b00, r_q} - {2'b00, rem_q[BW-1:0]} + {2'b00, bound_q} - (BW+2)'(1);
	end

	// next state
	always_comb begin
		st_nx = st_q;
		unique case (st_q)
			lcg_pkg::ST_IDLE: begin
				if (req_acc) begin
					st_nx = kind_ok ? lcg_pkg::ST_MUL : lcg_pkg::ST_DONE;
				end
			end
			lcg_pkg::ST_MUL: begin
				if (chunk_q == lcg_pkg::LAST_CHUNK) st_nx = lcg_pkg::ST_EVAL;
			end
			lcg_pkg::ST_EVAL: begin
				if ((kind_q == lcg_pkg::KIND_D53) && !second_q) begin
					st_nx = lcg_pkg::ST_MUL;
				end else if ((kind_q == lcg_pkg::KIND_INT) && !pow2) begin
					st_nx = lcg_pkg::ST_DIV;
				end else begin
					st_nx = lcg_pkg::ST_DONE;
				end
			end
			lcg_pkg::ST_DIV: begin
				if (div_cnt_q == lcg_pkg::LAST_DIV) st_nx = lcg_pkg::ST_CHECK;
			end
			lcg_pkg::ST_CHECK: begin
				st_nx = (chk[BW+1:BW] != 2'b00) ? lcg_pkg::ST_MUL : lcg_pkg::ST_DONE;
			end
			lcg_pkg::ST_DONE: begin
				if (!rsp_valid_q || !rsp_stall) st_nx = lcg_pkg::ST_IDLE;
			end
			default: st_nx = lcg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		req_stall     = (st_q != lcg_pkg::ST_IDLE);
		ctl.mul_last  = (st_q == lcg_pkg::ST_MUL) && (chunk_q == lcg_pkg::LAST_CHUNK);
		ctl.reject    = (st_q == lcg_pkg::ST_CHECK) && (chk[BW+1:BW] != 2'b00);
		ctl.eval_done = (st_q == lcg_pkg::ST_DONE) && (!rsp_valid_q || !rsp_stall);
		ctl.start_mul = (req_acc && kind_ok) || ctl.reject ||
				((st_q == lcg_pkg::ST_EVAL) && (kind_q == lcg_pkg::KIND_D53) && !second_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= lcg_pkg::ST_IDLE;
			seed_q      <= '0;
			state_q     <= {{(SW-lcg_pkg::MULT_W){1'b0}}, lcg_pkg::LCG_MULT};
			chunk_q     <= '0;
			div_cnt_q   <= '0;
			second_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (cfg_wr) begin
				seed_q  <= pwdata[SW-1:0];
				state_q <= pwdata[SW-1:0] ^ {{(SW-lcg_pkg::MULT_W){1'b0}}, lcg_pkg::LCG_MULT};
			end else if (ctl.mul_last) begin
				state_q <= acc_sum;
			end
			if (ctl.start_mul) begin
				chunk_q <= '0;
			end else if (st_q == lcg_pkg::ST_MUL) begin
				chunk_q <= chunk_q + 2'd1;
			end
			if (st_q == lcg_pkg::ST_DIV) begin
				div_cnt_q <= div_cnt_q + 5'd1;
			end else begin
				div_cnt_q <= '0;
			end
			if (req_acc) begin
				second_q <= 1'b0;
			end else if ((st_q == lcg_pkg::ST_EVAL) && (kind_q == lcg_pkg::KIND_D53)) begin
				second_q <= 1'b1;
			end
			if (ctl.eval_done) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (req_acc) begin
			kind_q  <= kind;
			nbits_q <= nbits_in;
			bound_q <= bound;
			res_q   <= '0;
		end
		if (ctl.start_mul) begin
			acc_q <= lcg_pkg::LCG_ADD;
		end else if (st_q == lcg_pkg::ST_MUL) begin
			acc_q <= acc_sum;
		end
		if (st_q == lcg_pkg::ST_EVAL) begin
			unique case (kind_q)
				lcg_pkg::KIND_RAW:  res_q <= raw_val;
				lcg_pkg::KIND_BOOL: res_q <= {{(VW-1){1'b0}}, state_q[47]};
				lcg_pkg::KIND_F24:  res_q <= {{(VW-24){1'b0}}, state_q[47:24]};
				lcg_pkg::KIND_D53: begin
					if (!second_q) hi_q <= state_q[47:22];
					else res_q <= {1'b0, hi_q, state_q[47:21]};
				end
				lcg_pkg::KIND_INT: begin
					res_q <= {{(VW-BW){1'b0}}, pow_prod[2*BW-1:BW]};
					r_q   <= draw31;
					dvd_q <= draw31;
					rem_q <= '0;
				end
				default: res_q <= '0;
			endcase
		end
		if (st_q == lcg_pkg::ST_DIV) begin
			rem_q <= rem_nx;
			dvd_q <= {dvd_q[BW-2:0], 1'b0};
		end
		if ((st_q == lcg_pkg::ST_CHECK) && !ctl.reject) begin
			res_q <= {{(VW-BW){1'b0}}, rem_q[BW-1:0]};
		end
		if (ctl.eval_done) begin
			value_q <= res_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> (st_q != lcg_pkg::ST_IDLE))
		else $error("request beat accepted but sequencer stayed idle");

	a_chunk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lcg_pkg::ST_MUL) |-> (chunk_q <= lcg_pkg::LAST_CHUNK))
		else $error("multiplier slice counter out of range");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == lcg_pkg::ST_DIV) |-> (div_cnt_q <= lcg_pkg::LAST_DIV))
		else $error("divider step counter out of range");

	a_int_below_bound: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == lcg_pkg::ST_DONE) && (kind_q == lcg_pkg::KIND_INT) && (bound_q != '0))
		|-> (res_q < {{(VW-BW){1'b0}}, bound_q}))
		else $error("bounded result not below bound");
`endif

endmodule
`default_nettype wire

### tb/sv/lcg48_value_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcg48_value_checker
// Watches the seed register port and both beat channels of the LCG source.
// It keeps its own copy of the generator state and predicts the value of
// each accepted request. Each result beat is then compared with the oldest
// prediction still waiting.
// ----------------------------------------------------------------------------
module lcg48_value_checker
	import lcg_pkg::*;
#(
	parameter logic [3:0] SEED_ADDR = 4'd0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [63:0]       pwdata,
	input  logic              pready,
	input  logic              req_valid,
	input  logic              req_stall,
	input  logic [2:0]        kind,
	input  logic [5:0]        bit_count,
	input  logic [30:0]       bound,
	input  logic              rsp_valid,
	input  logic              rsp_stall,
	input  logic signed [53:0] value,
	output int                fail_count,
	output int                outstanding,
	output int                checked,
	output int                redraws
);

	logic [STATE_W-1:0] gen_state;
	logic [53:0]        expected_values[$];

	initial begin
		fail_count = 0;
		checked = 0;
		redraws = 0;
		outstanding <= 0;
	end

	// advance once, return the top nbits as a signed 32-bit quantity
	function automatic longint draw_top(input int unsigned nbits);
		logic [31:0] top;
		gen_state = gen_state * STATE_W'(LCG_MULT) + LCG_ADD;
		if (nbits == 0)
			return 0;
		if (nbits > 32)
			nbits = 32;
		top = 32'(gen_state >> (STATE_W - nbits));
		return longint'(signed'(top));
	endfunction

	function automatic longint bounded_value(input logic [30:0] n);
		longint unsigned r, v, nn;
		int draws;
		nn = n;
		draws = 0;
		if (n == 0)
			return 0;
		if ((n & (n - 31'd1)) == 0) begin
			r = draw_top(31);
			return longint'((nn * r) >> 31);
		end
		do begin
			draws++;
			r = draw_top(31);
			v = r % nn;
		end while (r - v + nn - 1 >= 64'h8000_0000);
		redraws += draws - 1;
		return longint'(v);
	endfunction

	function automatic logic [53:0] predict_value(input logic [2:0] k, input logic [5:0] nb,
			input logic [30:0] n);
		longint res;
		longint unsigned hi, lo;
		case (k)
			KIND_RAW:  res = draw_top(nb);
			KIND_INT:  res = bounded_value(n);
			KIND_BOOL: res = (draw_top(1) != 0) ? 1 : 0;
			KIND_F24:  res = draw_top(24);
			KIND_D53: begin
				hi = draw_top(26);
				lo = draw_top(27);
				res = longint'((hi << 27) + lo);
			end
			default:   res = 0;
		endcase
		return res[53:0];
	endfunction

	task automatic log_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%t ERROR %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		logic [53:0] exp_v;
		if (!arst_n) begin
			gen_state = STATE_W'(LCG_MULT);
			expected_values.delete();
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
				gen_state = pwdata[STATE_W-1:0] ^ STATE_W'(LCG_MULT);
			if (rsp_valid && !rsp_stall) begin
				if (expected_values.size() == 0) begin
					log_failure($sformatf("result beat with nothing pending: value=%h", value));
				end else begin
					exp_v = expected_values.pop_front();
					checked++;
					if (value !== exp_v)
						log_failure($sformatf("value mismatch: expected %h, got %h",
							exp_v, value));
				end
			end
			if (req_valid && !req_stall)
				expected_values.push_back(predict_value(kind, bit_count, bound));
			outstanding <= expected_values.size();
		end
	end

endmodule

### tb/sv/tb_lcg48_random_source.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lcg48_random_source
// Drives requests of every kind, including unused codes, zero bounds and
// out-of-range bit counts, under four seed loads and three idle patterns,
// with one long result hold-off. A side checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_lcg48_random_source;
	import lcg_pkg::*;

	localparam logic [3:0] SEED_ADDR   = 4'd0;
	localparam int         CYCLE_LIMIT = 1_000_000;
	localparam int         HOLD_OFF    = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [2:0]  kind = KIND_RAW;
	logic [5:0]  bit_count = '0;
	logic [30:0] bound = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b1;
	logic signed [53:0] value;

	int fail_count, outstanding, checked, redraws;
	int send_idle_pct = 17;
	int stall_pct = 56;
	int hold_off_left = 0;
	int items_sent = 0;
	int cycles = 0;

	always #4 clk = ~clk;

	lcg48_random_source dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.bit_count (bit_count),
		.bound     (bound),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.value     (value)
	);

	lcg48_value_checker #(.SEED_ADDR(SEED_ADDR)) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.pready      (pready),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.bit_count   (bit_count),
		.bound       (bound),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.value       (value),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked),
		.redraws     (redraws)
	);

	always @(posedge clk) begin
		if (hold_off_left > 0) begin
			rsp_stall <= 1'b1;
			hold_off_left <= hold_off_left - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles, outstanding);
			$display("== FAIL ==");
			$finish;
		end
	end

	task automatic send_req(input logic [2:0] k, input logic [5:0] nb, input logic [30:0] n);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		kind <= k;
		bit_count <= nb;
		bound <= n;
		do @(posedge clk); while (req_stall);
		items_sent++;
	endtask

	task automatic send_random_req();
		logic [2:0]  k;
		logic [5:0]  nb;
		logic [30:0] n;
		int unsigned s;
		k = ($urandom_range(99) < 8) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
		s = $urandom_range(99);
		if (s < 5)
			nb = '0;
		else if (s < 12)
			nb = 6'($urandom_range(63, 33));
		else
			nb = 6'($urandom_range(32, 1));
		s = $urandom_range(99);
		if (s < 3)
			n = '0;
		else if (s < 25)
			n = 31'd1 << $urandom_range(30, 0);
		else if (s < 45)
			n = 31'($urandom_range(100, 1));
		else if (s < 60)
			n = 31'h7FFF_FFFF - 31'($urandom_range(1000));
		else if (s < 75)
			n = 31'h4000_0000 + 31'($urandom_range(1000, 1));
		else
			n = 31'($urandom());
		send_req(k, nb, n);
	endtask

	// block goes idle: no request offered, every predicted value returned
	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_seed(input logic [47:0] seed);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= SEED_ADDR;
		pwdata <= {16'd0, seed};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_seed(48'h0);
		send_req(KIND_RAW, 6'd1, 31'd0);
		send_req(KIND_RAW, 6'd32, 31'd0);
		send_req(KIND_RAW, 6'd0, 31'd5);
		send_req(KIND_RAW, 6'd33, 31'd0);
		send_req(KIND_RAW, 6'd63, 31'h7FFF_FFFF);
		send_req(KIND_RAW, 6'd16, 31'd0);
		send_req(KIND_INT, 6'd0, 31'd1);
		send_req(KIND_INT, 6'd0, 31'h4000_0000);
		send_req(KIND_INT, 6'd63, 31'd7);
		send_req(KIND_INT, 6'd1, 31'h7FFF_FFFF);
		send_req(KIND_INT, 6'd0, 31'h4000_0001);
		send_req(KIND_INT, 6'd32, 31'd0);
		send_req(KIND_INT, 6'd0, 31'd3);
		send_req(KIND_BOOL, 6'd0, 31'd0);
		send_req(KIND_F24, 6'd63, 31'h7FFF_FFFF);
		send_req(KIND_D53, 6'd0, 31'd0);
		send_req(3'd5, 6'd32, 31'd9);
		send_req(3'd6, 6'd63, 31'h7FFF_FFFF);
		send_req(3'd7, 6'd1, 31'd0);
		drain();

		// state comes out all zero
		write_seed(48'h5_DEEC_E66D);
		repeat (280) send_random_req();
		drain();

		send_idle_pct = 56;
		stall_pct = 17;
		write_seed(48'hFFFF_FFFF_FFFF);
		repeat (280) send_random_req();
		drain();

		send_idle_pct = 0;
		stall_pct = 0;
		write_seed({16'($urandom()), 32'($urandom())});
		hold_off_left <= HOLD_OFF;
		repeat (290) send_random_req();
		drain();
		repeat (64) @(posedge clk);

		$display("Sent %0d requests (all kinds, unused codes, zero bound and odd bit counts)",
			items_sent);
		$display("under 4 seed loads; %0d values compared, %0d bounded redraws predicted.",
			checked, redraws);
		if (outstanding != 0)
			$display("%0d predicted values never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
